>>> hw/rtl/shelf_rect_packer_core_assert.svh
// Assertion macros shared by the shelf packer RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef SHELF_RECT_PACKER_CORE_ASSERT_SVH
`define SHELF_RECT_PACKER_CORE_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define SHRP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define SHRP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/shrp_pkg.sv
// Types and constants of the shelf rectangle packer.
// No dependencies; used by every module of the block.
package shrp_pkg;

    localparam int RECT_W  = 12;
    localparam int GAP_W   = 8;
    localparam int SIDE_W  = 13;
    localparam int WIDE_W  = SIDE_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIDE_W-1:0] MAX_SIDE_RST = 13'd2048;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP      = 1'b0,
        CFG_MAX_SIDE = 1'b1
    } cfg_idx_t;

    // Running packer state carried from one rectangle to the next.
    typedef struct packed {
        logic [SIDE_W-1:0] cursor_x;
        logic [SIDE_W-1:0] shelf_y;
        logic [SIDE_W-1:0] shelf_height;
        logic [SIDE_W-1:0] used_width;
        logic [SIDE_W-1:0] used_height;
        logic              atlas_full;
    } pack_state_t;

    typedef struct packed {
        logic              placed;
        logic [RECT_W-1:0] pos_x;
        logic [RECT_W-1:0] pos_y;
        logic [SIDE_W-1:0] atlas_width;
        logic [SIDE_W-1:0] atlas_height;
        logic              set_done;
    } pack_result_t;

endpackage

>>> hw/rtl/shrp_round.sv
// Rounds an extent up to a power of two (at least 2) capped at lim; 0 gives 0.
// Depends on shrp_pkg.
module shrp_round
    import shrp_pkg::*;
(
    input  logic [SIDE_W-1:0] extent,
    input  logic [SIDE_W-1:0] lim,
    output logic [SIDE_W-1:0] size
);

    logic [SIDE_W-1:0] smear;
    logic [WIDE_W-1:0] pow2;

    always_comb
    begin
        // Smearing the bits of extent-1 downward gives the next power of two minus one.
        smear = extent - 13'd1;
        smear = smear | (smear >> 1);
        smear = smear | (smear >> 2);
        smear = smear | (smear >> 4);
        smear = smear | (smear >> 8);
        pow2 = {1'b0, smear} + 14'd1;
        if (pow2 < 14'd2)
        begin
            pow2 = 14'd2;
        end
        if (pow2 > {1'b0, lim})
        begin
            pow2 = {1'b0, lim};
        end
        if (extent == '0)
        begin
            size = '0;
        end
        else
        begin
            size = pow2[SIDE_W-1:0];
        end
    end

endmodule

>>> hw/rtl/shrp_place.sv
// Placement step: shelf wrap, bottom check, extent tracking and the end-of-set size.
// Depends on shrp_pkg and shrp_round.
module shrp_place
    import shrp_pkg::*;
(
    input  pack_state_t       st,
    input  logic [RECT_W-1:0] box_width,
    input  logic [RECT_W-1:0] box_height,
    input  logic              last_rect,
    input  logic [GAP_W-1:0]  gap,
    input  logic [SIDE_W-1:0] lim,
    output pack_state_t       st_next,
    output pack_result_t      res
);

    logic              go;
    logic [SIDE_W-1:0] rw;
    logic [SIDE_W-1:0] rh;
    logic [WIDE_W-1:0] right0;
    logic [WIDE_W-1:0] right;
    logic [WIDE_W-1:0] bottom;
    logic              wrap;
    logic [SIDE_W-1:0] sy_w;
    logic [SIDE_W-1:0] cx_w;
    logic [SIDE_W-1:0] sh_w;
    pack_state_t       st_upd;
    pack_result_t      res_pl;
    logic [SIDE_W-1:0] aw_round;
    logic [SIDE_W-1:0] ah_round;
    logic              extent_ok;

    always_comb
    begin
        go     = !st.atlas_full && (box_width != '0) && (box_height != '0);
        rw     = {1'b0, box_width} + {5'b0, gap};
        rh     = {1'b0, box_height} + {5'b0, gap};
        right0 = {1'b0, st.cursor_x} + {1'b0, rw};
        wrap   = right0 > {1'b0, lim};
        // A new shelf opens below the tallest rectangle of the current one.
        sy_w   = wrap ? (st.shelf_y + st.shelf_height) : st.shelf_y;
        cx_w   = wrap ? '0 : st.cursor_x;
        sh_w   = wrap ? '0 : st.shelf_height;
        right  = wrap ? {1'b0, rw} : right0;
        bottom = {1'b0, sy_w} + {1'b0, rh};

        st_upd = st;
        res_pl = '0;
        if (go)
        begin
            st_upd.shelf_y      = sy_w;
            st_upd.cursor_x     = cx_w;
            st_upd.shelf_height = sh_w;
            if (bottom > {1'b0, lim})
            begin
                st_upd.atlas_full = 1'b1;
            end
            else
            begin
                res_pl.placed   = 1'b1;
                res_pl.pos_x    = cx_w[RECT_W-1:0];
                res_pl.pos_y    = sy_w[RECT_W-1:0];
                st_upd.cursor_x = right[SIDE_W-1:0];
                if (rh > sh_w)
                begin
                    st_upd.shelf_height = rh;
                end
                if (right > {1'b0, st.used_width})
                begin
                    st_upd.used_width = right[SIDE_W-1:0];
                end
                if (bottom > {1'b0, st.used_height})
                begin
                    st_upd.used_height = bottom[SIDE_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        extent_ok = (st_upd.used_width != '0) && (st_upd.used_height != '0);
        st_next   = st_upd;
        res       = res_pl;
        if (last_rect)
        begin
            st_next          = '0;
            res.set_done     = 1'b1;
            res.atlas_width  = extent_ok ? aw_round : '0;
            res.atlas_height = extent_ok ? ah_round : '0;
        end
    end

    shrp_round u_round_w (
        .extent (st_upd.used_width),
        .lim    (lim),
        .size   (aw_round)
    );

    shrp_round u_round_h (
        .extent (st_upd.used_height),
        .lim    (lim),
        .size   (ah_round)
    );

endmodule

>>> hw/rtl/shelf_rect_packer_core.sv
// Top level of the shelf rectangle packer: input register, packer state, result register.
// Depends on shrp_pkg, shrp_place and shelf_rect_packer_core_assert.svh.
//
// Usage: rectangles arrive on the in channel (box_width, box_height, last_rect),
// sorted by ascending height. Each input transaction yields exactly one result
// transaction on the out channel with placed, pos_x, pos_y, set_done and, on the
// last rectangle of a set, atlas_width and atlas_height.
// The cfg channel writes gap (index 0) and max_side (index 1); it is always ready.
// The user must write it only while the block is idle; the block does not enforce it.
// A rectangle is captured in the input register at acceptance, and its result is
// loaded into the output register, raising out_valid, once that register is empty
// or being read. The block takes one rectangle per cycle while out_ready stays
// high, through the loop around the packer state (cursor, shelf and extent registers).
// Reset clears the packer state, empties both registers, sets gap to 0 and
// max_side to 2048. When the receiver holds out_ready low, the result stays put,
// one more rectangle is held in the input register, and then in_ready drops.
// The state clears after the last rectangle of a set, ready for the next set.
`include "shelf_rect_packer_core_assert.svh"

module shelf_rect_packer_core
    import shrp_pkg::*;
#(
    parameter int SIDE_LIMIT = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIDE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [RECT_W-1:0]    box_width,
    input  logic [RECT_W-1:0]    box_height,
    input  logic                 last_rect,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 placed,
    output logic [RECT_W-1:0]    pos_x,
    output logic [RECT_W-1:0]    pos_y,
    output logic [SIDE_W-1:0]    atlas_width,
    output logic [SIDE_W-1:0]    atlas_height,
    output logic                 set_done
);

    // The state is 13 bits wide, so a limit above 8191 never saturates max_side.
    localparam int               LIM_CAP   = (SIDE_LIMIT > 8191) ? 8191 : SIDE_LIMIT;
    localparam logic [SIDE_W-1:0] LIM_CAP_V = SIDE_W'(LIM_CAP);

    logic [GAP_W-1:0]  gap_reg;
    logic [SIDE_W-1:0] max_side_reg;
    logic [SIDE_W-1:0] lim;

    logic              s0_valid_reg;
    logic [RECT_W-1:0] s0_width_reg;
    logic [RECT_W-1:0] s0_height_reg;
    logic              s0_last_reg;

    pack_state_t       state_reg;
    pack_state_t       state_next;
    pack_result_t      res_next;
    pack_result_t      res_reg;
    logic              out_valid_reg;

    logic              advance;
    logic              in_take;

    assign cfg_ready = 1'b1;
    assign lim       = (max_side_reg > LIM_CAP_V) ? LIM_CAP_V : max_side_reg;

    assign advance  = s0_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s0_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg      <= '0;
            max_side_reg <= MAX_SIDE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GAP:      gap_reg      <= cfg_data[GAP_W-1:0];
                CFG_MAX_SIDE: max_side_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    shrp_place u_place (
        .st          (state_reg),
        .box_width   (s0_width_reg),
        .box_height  (s0_height_reg),
        .last_rect   (s0_last_reg),
        .gap         (gap_reg),
        .lim         (lim),
        .st_next     (state_next),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s0_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s0_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s0_width_reg  <= box_width;
            s0_height_reg <= box_height;
            s0_last_reg   <= last_rect;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign placed       = res_reg.placed;
    assign pos_x        = res_reg.pos_x;
    assign pos_y        = res_reg.pos_y;
    assign atlas_width  = res_reg.atlas_width;
    assign atlas_height = res_reg.atlas_height;
    assign set_done     = res_reg.set_done;

    `SHRP_ASSERT_NOW(a_unplaced_at_origin, out_valid && !placed, pos_x == '0 && pos_y == '0, "unplaced rectangle carries a position")
    `SHRP_ASSERT_NOW(a_size_only_at_end, out_valid && !set_done, atlas_width == '0 && atlas_height == '0, "atlas size reported before the end of a set")
    `SHRP_ASSERT_NOW(a_size_pair, out_valid && set_done && atlas_width != '0, atlas_height != '0, "atlas width without atlas height")
    `SHRP_ASSERT_NEXT(a_clear_after_last, advance && s0_last_reg, state_reg == '0, "packer state not cleared after the last rectangle")
    `SHRP_ASSERT_NEXT(a_full_places_nothing, advance && state_reg.atlas_full, !res_reg.placed, "rectangle placed after the atlas filled")

endmodule
